// ----- sv/rapsfp_pkg.sv -----
// Shared types and constants for the ring protection frame parser.
package rapsfp_pkg;

	localparam int unsigned MIN_FRAME_BYTES = 55;
	localparam int unsigned NODE_W = 48;
	localparam int unsigned POS_W = 6;
	localparam logic [POS_W-1:0] POS_MAX = 6'd63;

	// Byte offsets in an untagged frame; a VLAN tag moves the CFM offsets by TAG_SHIFT.
	localparam logic [POS_W-1:0] OFS_RING = 6'd5;
	localparam logic [POS_W-1:0] OFS_TYPE_HI = 6'd12;
	localparam logic [POS_W-1:0] OFS_TYPE_LO = 6'd13;
	localparam logic [POS_W-1:0] OFS_VERSION = 6'd14;
	localparam logic [POS_W-1:0] OFS_OPCODE = 6'd15;
	localparam logic [POS_W-1:0] OFS_REQUEST = 6'd18;
	localparam logic [POS_W-1:0] OFS_FLAGS = 6'd19;
	localparam logic [POS_W-1:0] OFS_NODE_FIRST = 6'd20;
	localparam logic [POS_W-1:0] OFS_NODE_LAST = 6'd25;
	localparam logic [POS_W-1:0] TAG_SHIFT = 6'd4;

	localparam logic [7:0] VLAN_TPID_HI = 8'h81;
	localparam logic [7:0] VLAN_TPID_LO = 8'h00;
	localparam logic [7:0] CFM_OPCODE_RAPS = 8'd40;
	localparam logic [4:0] CFM_VERSION_MAX = 5'd2;

	// R-APS request codes that the parser accepts.
	localparam logic [3:0] REQ_NR = 4'd0;
	localparam logic [3:0] REQ_MS = 4'd7;
	localparam logic [3:0] REQ_SF = 4'd11;
	localparam logic [3:0] REQ_FS = 4'd13;

	// Verdict codes, in check order after success.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_DEST    = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_BAD_OPCODE  = 3'd4,
		ST_BAD_REQUEST = 3'd5
	} status_t;

	// Fields gathered from the header while the frame passes.
	typedef struct packed {
		logic              dest_mismatch;
		logic [7:0]        ring_byte;
		logic              tag_seen;
		logic [4:0]        version_field;
		logic [7:0]        opcode_byte;
		logic [3:0]        request_nibble;
		logic [2:0]        flag_bits;
		logic [NODE_W-1:0] node_shift;
	} frame_fields_t;

	// One verdict as it leaves the block.
	typedef struct packed {
		status_t           status;
		logic [7:0]        ring_number;
		logic [3:0]        request_code;
		logic [2:0]        status_flags;
		logic [NODE_W-1:0] sender_node;
		logic              tagged_res;
		logic              from_self;
	} verdict_t;

	// Expected destination address prefix byte at a given position.
	function automatic logic [7:0] dest_prefix(input logic [2:0] idx);
		logic [7:0] val;
		case (idx)
			3'd0: val = 8'h01;
			3'd1: val = 8'h19;
			3'd2: val = 8'hA7;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

// ----- sv/rapsfp_byte_if.sv -----
// Channel that carries one frame byte per item into the parser.
interface rapsfp_byte_if import rapsfp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ----- sv/rapsfp_verdict_if.sv -----
// Channel that carries one parse verdict per item out of the parser.
interface rapsfp_verdict_if import rapsfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [7:0]        ring_number;
	logic [3:0]        request_code;
	logic [2:0]        status_flags;
	logic [NODE_W-1:0] sender_node;
	logic              tagged_res;
	logic              from_self;

	modport source (
		output valid, output status, output ring_number, output request_code,
		output status_flags, output sender_node, output tagged_res, output from_self,
		input ready
	);
	modport sink (
		input valid, input status, input ring_number, input request_code,
		input status_flags, input sender_node, input tagged_res, input from_self,
		output ready
	);
endinterface

// ----- sv/rapsfp_verdict.sv -----
// Verdict logic: runs the frame checks in order and masks fields of a failed frame.
module rapsfp_verdict import rapsfp_pkg::*; (
	input  frame_fields_t      fields,
	input  logic [POS_W-1:0]   last_pos,
	input  logic [NODE_W-1:0]  local_node,
	output verdict_t           verdict
);

	logic    too_short;
	logic    req_known;
	status_t status;

	// Frame length is the position of the last byte plus one.
	assign too_short = ({1'b0, last_pos} + 7'd1) < 7'(MIN_FRAME_BYTES);

	assign req_known = (fields.request_nibble == REQ_NR) || (fields.request_nibble == REQ_MS)
		|| (fields.request_nibble == REQ_SF) || (fields.request_nibble == REQ_FS);

	// First failing check sets the status.
	always_comb begin
		if (too_short) begin
			status = ST_TOO_SHORT;
		end else if (fields.dest_mismatch) begin
			status = ST_BAD_DEST;
		end else if (fields.version_field > CFM_VERSION_MAX) begin
			status = ST_BAD_VERSION;
		end else if (fields.opcode_byte != CFM_OPCODE_RAPS) begin
			status = ST_BAD_OPCODE;
		end else if (!req_known) begin
			status = ST_BAD_REQUEST;
		end else begin
			status = ST_OK;
		end
	end

	// A failed frame reports only its status.
	always_comb begin
		verdict = '0;
		verdict.status = status;
		if (status == ST_OK) begin
			verdict.ring_number  = fields.ring_byte;
			verdict.request_code = fields.request_nibble;
			verdict.status_flags = fields.flag_bits;
			verdict.sender_node  = fields.node_shift;
			verdict.tagged_res   = fields.tag_seen;
			verdict.from_self    = (fields.node_shift == local_node);
		end
	end

endmodule

// ----- sv/ring_aps_frame_parser.sv -----
// Top level of the ring protection (R-APS) frame parser.
// Throughput: one frame byte per cycle, with no gaps between frames, unless a verdict waits on a stalled sink.
// Latency: the verdict is valid in the cycle after the last byte is accepted.
// The byte channel stalls only while a verdict waits and the sink does not take it.
// Reset clears the parse state, the pending verdict and the local node address.
module ring_aps_frame_parser import rapsfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rapsfp_byte_if.sink          frame,
	rapsfp_verdict_if.source     verdict,
	input  logic                 node_wr_en,
	input  logic [NODE_W-1:0]    node_wr_data
);

	logic [NODE_W-1:0] local_node_q;
	logic [POS_W-1:0]  pos_q;
	frame_fields_t     fields_q;
	frame_fields_t     fields_next;
	logic              accept;
	logic [POS_W-1:0]  tag_ofs;
	verdict_t          verdict_comb;
	verdict_t          verdict_q;
	logic              out_valid_q;
	logic [7:0]        type_hi_q;

	// A byte enters whenever the result register is free or being emptied.
	assign frame.ready = !out_valid_q || verdict.ready;
	assign accept = frame.valid && frame.ready;

	// Local node address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_node_q <= '0;
		end else if (node_wr_en) begin
			local_node_q <= node_wr_data;
		end
	end

	// Field capture for the byte at the current position.
	assign tag_ofs = fields_q.tag_seen ? TAG_SHIFT : '0;

	always_comb begin
		fields_next = fields_q;
		if (pos_q < OFS_RING) begin
			if (frame.frame_byte != dest_prefix(pos_q[2:0])) begin
				fields_next.dest_mismatch = 1'b1;
			end
		end else if (pos_q == OFS_RING) begin
			fields_next.ring_byte = frame.frame_byte;
		end else if (pos_q == OFS_TYPE_HI) begin
			fields_next.opcode_byte = fields_q.opcode_byte;
		end else if (pos_q == OFS_TYPE_LO) begin
			fields_next.tag_seen = (type_hi_q == VLAN_TPID_HI)
				&& (frame.frame_byte == VLAN_TPID_LO);
		end else if (pos_q == OFS_VERSION + tag_ofs) begin
			fields_next.version_field = frame.frame_byte[4:0];
		end else if (pos_q == OFS_OPCODE + tag_ofs) begin
			fields_next.opcode_byte = frame.frame_byte;
		end else if (pos_q == OFS_REQUEST + tag_ofs) begin
			fields_next.request_nibble = frame.frame_byte[7:4];
		end else if (pos_q == OFS_FLAGS + tag_ofs) begin
			fields_next.flag_bits = frame.frame_byte[7:5];
		end else if ((pos_q >= OFS_NODE_FIRST + tag_ofs)
				&& (pos_q <= OFS_NODE_LAST + tag_ofs)) begin
			fields_next.node_shift = {fields_q.node_shift[NODE_W-9:0], frame.frame_byte};
		end
	end

	// High ethertype byte, held until the low byte decides the tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_hi_q <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				type_hi_q <= '0;
			end else if (pos_q == OFS_TYPE_HI) begin
				type_hi_q <= frame.frame_byte;
			end
		end
	end

	// Parse state: position saturates, everything clears after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fields_q <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				pos_q    <= '0;
				fields_q <= '0;
			end else begin
				fields_q <= fields_next;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

	rapsfp_verdict u_verdict (
		.fields     (fields_next),
		.last_pos   (pos_q),
		.local_node (local_node_q),
		.verdict    (verdict_comb)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && frame.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept && frame.last_byte) begin
			verdict_q <= verdict_comb;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.status       = verdict_q.status;
	assign verdict.ring_number  = verdict_q.ring_number;
	assign verdict.request_code = verdict_q.request_code;
	assign verdict.status_flags = verdict_q.status_flags;
	assign verdict.sender_node  = verdict_q.sender_node;
	assign verdict.tagged_res   = verdict_q.tagged_res;
	assign verdict.from_self    = verdict_q.from_self;

endmodule

// ----- tb/ring_aps_frame_parser_tb.sv -----
// Self-checking testbench for the R-APS frame parser: random frames, stalls and node settings.
`timescale 1ns / 1ps

module ring_aps_frame_parser_tb;
	import rapsfp_pkg::*;

	localparam int LIMIT_CYCLES = 800_000;
	localparam int HDR_BYTES = 30;
	localparam int ITEM_TARGET = 1650;
	localparam logic [39:0] DST_PREFIX = 40'h01_19_A7_00_00;
	localparam logic [15:0] CFM_ETYPE = 16'h8902;

	// Ways a random frame may be damaged.
	typedef enum int {
		FLAW_DEST,
		FLAW_VERSION,
		FLAW_OPCODE,
		FLAW_REQUEST
	} frame_flaw_t;

	// One byte waiting for the driver, with the idle cycles that follow it.
	typedef struct {
		logic [7:0] data;
		logic       last;
		int         idle_after;
	} byte_item_t;

	// Header content of one frame to be built.
	typedef struct {
		logic [15:0] etype;
		logic [7:0]  ring;
		logic [7:0]  ver;
		logic [7:0]  op;
		logic [7:0]  req;
		logic [7:0]  flags;
		logic [47:0] node;
		int          len;
		int          dst_idx;
		logic [7:0]  dst_xor;
	} frame_spec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        node_wr_en;
	logic [47:0] node_wr_data;

	rapsfp_byte_if    frame_ch ();
	rapsfp_verdict_if verdict_ch ();

	ring_aps_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame_ch),
		.verdict      (verdict_ch),
		.node_wr_en   (node_wr_en),
		.node_wr_data (node_wr_data)
	);

	always #4 clk = ~clk;

	byte_item_t byte_queue[$];
	verdict_t   expected_verdicts[$];
	int         bytes_queued = 0;
	int         bytes_taken = 0;
	int         mismatch_count = 0;
	bit         gaps_on = 1'b0;
	bit         stall_on = 1'b0;
	int         idle_left;
	int         stall_left;
	int         pause;
	byte_item_t drv_item;
	verdict_t   want;

	// Parser state as the block should hold it.
	logic [5:0]  pos_cnt = '0;
	logic        vlan_seen = 1'b0;
	logic [7:0]  tpid_hi = '0;
	logic        dst_bad = 1'b0;
	logic [7:0]  ring_id = '0;
	logic [4:0]  cfm_ver = '0;
	logic [7:0]  cfm_op = '0;
	logic [3:0]  req_code = '0;
	logic [2:0]  flag_top = '0;
	logic [47:0] node_acc = '0;
	logic [47:0] my_node = '0;

	// Short gaps are common, long ones rare.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Advance the parser state by one accepted byte; the last byte yields a verdict.
	function automatic void parse_byte(input logic [7:0] b, input logic fin);
		logic [5:0] ofs;
		status_t    st;
		verdict_t   v;
		ofs = vlan_seen ? TAG_SHIFT : 6'd0;
		if (pos_cnt < OFS_RING) begin
			if (b != DST_PREFIX[39 - 8 * int'(pos_cnt) -: 8])
				dst_bad = 1'b1;
		end else if (pos_cnt == OFS_RING) begin
			ring_id = b;
		end else if (pos_cnt == OFS_TYPE_HI) begin
			tpid_hi = b;
		end else if (pos_cnt == OFS_TYPE_LO) begin
			vlan_seen = (tpid_hi == VLAN_TPID_HI) && (b == VLAN_TPID_LO);
		end else if (pos_cnt == OFS_VERSION + ofs) begin
			cfm_ver = b[4:0];
		end else if (pos_cnt == OFS_OPCODE + ofs) begin
			cfm_op = b;
		end else if (pos_cnt == OFS_REQUEST + ofs) begin
			req_code = b[7:4];
		end else if (pos_cnt == OFS_FLAGS + ofs) begin
			flag_top = b[7:5];
		end else if (pos_cnt >= OFS_NODE_FIRST + ofs && pos_cnt <= OFS_NODE_LAST + ofs) begin
			node_acc = {node_acc[39:0], b};
		end

		if (!fin) begin
			if (pos_cnt != POS_MAX)
				pos_cnt = pos_cnt + 1'b1;
		end else begin
			// The first failing check in order sets the status.
			if (int'(pos_cnt) + 1 < MIN_FRAME_BYTES)
				st = ST_TOO_SHORT;
			else if (dst_bad)
				st = ST_BAD_DEST;
			else if (cfm_ver > CFM_VERSION_MAX)
				st = ST_BAD_VERSION;
			else if (cfm_op != CFM_OPCODE_RAPS)
				st = ST_BAD_OPCODE;
			else if (req_code != REQ_NR && req_code != REQ_MS && req_code != REQ_SF
					&& req_code != REQ_FS)
				st = ST_BAD_REQUEST;
			else
				st = ST_OK;
			v = '0;
			v.status = st;
			if (st == ST_OK) begin
				v.ring_number = ring_id;
				v.request_code = req_code;
				v.status_flags = flag_top;
				v.sender_node = node_acc;
				v.tagged_res = vlan_seen;
				v.from_self = (node_acc == my_node);
			end
			expected_verdicts.push_back(v);

			// A verdict clears everything but the node address.
			pos_cnt = '0;
			vlan_seen = 1'b0;
			tpid_hi = '0;
			dst_bad = 1'b0;
			ring_id = '0;
			cfm_ver = '0;
			cfm_op = '0;
			req_code = '0;
			flag_top = '0;
			node_acc = '0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [47:0] exp_val,
			input logic [47:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// Byte driver: loads the next queued item whenever the channel is free and no idle gap is pending.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
			frame_ch.frame_byte <= '0;
			frame_ch.last_byte <= 1'b0;
			idle_left <= 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				parse_byte(frame_ch.frame_byte, frame_ch.last_byte);
				bytes_taken++;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (idle_left > 0) begin
					frame_ch.valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (byte_queue.size() > 0) begin
					drv_item = byte_queue.pop_front();
					frame_ch.valid <= 1'b1;
					frame_ch.frame_byte <= drv_item.data;
					frame_ch.last_byte <= drv_item.last;
					idle_left <= drv_item.idle_after;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Verdict monitor: checks each accepted item and stalls the sink at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (verdict_ch.valid && verdict_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict item arrived with none expected");
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("status", want.status, verdict_ch.status);
					check_field("ring_number", want.ring_number, verdict_ch.ring_number);
					check_field("request_code", want.request_code, verdict_ch.request_code);
					check_field("status_flags", want.status_flags, verdict_ch.status_flags);
					check_field("sender_node", want.sender_node, verdict_ch.sender_node);
					check_field("tagged_res", want.tagged_res, verdict_ch.tagged_res);
					check_field("from_self", want.from_self, verdict_ch.from_self);
				end
			end
			if (stall_left > 0) begin
				verdict_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				pause = stall_on ? idle_length() : 0;
				verdict_ch.ready <= (pause == 0);
				stall_left <= (pause == 0) ? 0 : pause - 1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic fin);
		byte_item_t it;
		it.data = d;
		it.last = fin;
		it.idle_after = gaps_on ? idle_length() : 0;
		byte_queue.push_back(it);
		bytes_queued++;
	endtask

	// A well-formed R-APS frame with random filler in the fields that do not matter.
	function automatic frame_spec_t raps_frame(input bit vlan, input logic [3:0] req,
			input logic [47:0] node, input int len);
		frame_spec_t fs;
		fs.etype = vlan ? {VLAN_TPID_HI, VLAN_TPID_LO} : CFM_ETYPE;
		fs.ring = 8'($urandom);
		fs.ver = {3'($urandom), 5'($urandom_range(0, 2))};
		fs.op = CFM_OPCODE_RAPS;
		fs.req = {req, 4'($urandom)};
		fs.flags = 8'($urandom);
		fs.node = node;
		fs.len = len;
		fs.dst_idx = 0;
		fs.dst_xor = '0;
		return fs;
	endfunction

	// Lay out the header at its offsets and queue the frame byte by byte.
	task automatic queue_frame(input frame_spec_t fs);
		logic [7:0] hdr [HDR_BYTES];
		int t;
		int k;
		for (k = 0; k < HDR_BYTES; k++)
			hdr[k] = 8'($urandom);
		for (k = 0; k < 5; k++)
			hdr[k] = DST_PREFIX[39 - 8 * k -: 8];
		hdr[fs.dst_idx] = hdr[fs.dst_idx] ^ fs.dst_xor;
		hdr[5] = fs.ring;
		hdr[12] = fs.etype[15:8];
		hdr[13] = fs.etype[7:0];
		t = (fs.etype == {VLAN_TPID_HI, VLAN_TPID_LO}) ? 4 : 0;
		if (t != 0) begin
			hdr[16] = CFM_ETYPE[15:8];
			hdr[17] = CFM_ETYPE[7:0];
		end
		hdr[14 + t] = fs.ver;
		hdr[15 + t] = fs.op;
		hdr[18 + t] = fs.req;
		hdr[19 + t] = fs.flags;
		for (k = 0; k < 6; k++)
			hdr[20 + t + k] = fs.node[47 - 8 * k -: 8];
		for (k = 0; k < fs.len; k++)
			push_byte(k < HDR_BYTES ? hdr[k] : 8'($urandom), k == fs.len - 1);
	endtask

	task automatic queue_noise(input int len);
		int k;
		for (k = 0; k < len; k++)
			push_byte(8'($urandom), k == len - 1);
	endtask

	// Mostly well-formed frames; the rest are damaged, truncated or pure noise.
	task automatic random_frame();
		frame_spec_t fs;
		int          kind;
		logic [3:0]  rq;
		logic [7:0]  op;
		logic [47:0] nd;
		kind = $urandom_range(0, 99);
		nd = ($urandom_range(0, 2) == 0) ? my_node : {16'($urandom), 32'($urandom)};
		case ($urandom_range(0, 3))
			0: rq = REQ_NR;
			1: rq = REQ_MS;
			2: rq = REQ_SF;
			default: rq = REQ_FS;
		endcase
		fs = raps_frame($urandom_range(0, 3) == 0, rq, nd,
			($urandom_range(0, 9) == 0) ? $urandom_range(71, 127) : $urandom_range(55, 70));
		if (kind < 15) begin
			queue_noise($urandom_range(1, 90));
		end else begin
			if (kind < 27) begin
				fs.len = $urandom_range(1, 54);
			end else if (kind < 40) begin
				case (frame_flaw_t'($urandom_range(0, 3)))
					FLAW_DEST: begin
						fs.dst_idx = $urandom_range(0, 4);
						fs.dst_xor = 8'($urandom_range(1, 255));
					end
					FLAW_VERSION: fs.ver = {3'($urandom), 5'($urandom_range(3, 31))};
					FLAW_OPCODE: begin
						do
							op = 8'($urandom);
						while (op == CFM_OPCODE_RAPS);
						fs.op = op;
					end
					default: begin
						do
							rq = 4'($urandom);
						while (rq == REQ_NR || rq == REQ_MS || rq == REQ_SF || rq == REQ_FS);
						fs.req = {rq, 4'($urandom)};
					end
				endcase
			end else if (kind < 45) begin
				// Some other ethertype, never the VLAN tag.
				fs.etype = 16'($urandom);
				if (fs.etype == {VLAN_TPID_HI, VLAN_TPID_LO})
					fs.etype[0] = 1'b1;
			end
			queue_frame(fs);
		end
	endtask

	// Wait until every queued byte is taken and every verdict has been checked.
	task automatic drain();
		while (bytes_taken != bytes_queued || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node(input logic [47:0] val);
		@(posedge clk);
		node_wr_en <= 1'b1;
		node_wr_data <= val;
		@(posedge clk);
		node_wr_en <= 1'b0;
		my_node = val;
	endtask

	// Watchdog on the whole run.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Stimulus: directed frames, then random phases with changing node address.
	initial begin
		frame_spec_t fs;
		int          phase;
		int          k;
		logic [47:0] nd;

		frame_ch.valid = 1'b0;
		frame_ch.frame_byte = '0;
		frame_ch.last_byte = 1'b0;
		verdict_ch.ready = 1'b0;
		node_wr_en = 1'b0;
		node_wr_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		gaps_on = 1'b1;
		stall_on = 1'b1;

		// Minimum length, all-zero fields, node equal to the reset address.
		fs = raps_frame(1'b0, REQ_NR, 48'h0, 55);
		fs.ring = 8'h00;
		fs.flags = 8'h00;
		fs.ver = 8'h00;
		fs.req = {REQ_NR, 4'hF};
		queue_frame(fs);
		// Tagged, all-ones fields, highest accepted version under set level bits.
		fs = raps_frame(1'b1, REQ_MS, '1, 59);
		fs.ring = 8'hFF;
		fs.flags = 8'hFF;
		fs.ver = 8'hE2;
		queue_frame(fs);
		queue_frame(raps_frame(1'b0, REQ_SF, 48'h0123_4567_89AB, 64));
		// Long frame that drives the byte count into saturation.
		queue_frame(raps_frame(1'b1, REQ_FS, 48'h8000_0000_0001, 120));
		// One byte short, and a frame of a single byte.
		queue_frame(raps_frame(1'b0, REQ_NR, 48'h0, 54));
		queue_noise(1);
		// Short length wins over a wrong destination.
		fs = raps_frame(1'b0, REQ_NR, 48'h0, 54);
		fs.dst_idx = 1;
		fs.dst_xor = 8'h40;
		queue_frame(fs);
		fs = raps_frame(1'b0, REQ_NR, 48'h0, 60);
		fs.dst_idx = 2;
		fs.dst_xor = 8'h01;
		queue_frame(fs);
		fs = raps_frame(1'b1, REQ_NR, 48'h0, 60);
		fs.dst_idx = 4;
		fs.dst_xor = 8'h80;
		queue_frame(fs);
		// Version errors, one of them also with a bad opcode.
		fs = raps_frame(1'b0, REQ_MS, 48'h0, 55);
		fs.ver = 8'h03;
		queue_frame(fs);
		fs = raps_frame(1'b1, REQ_MS, 48'h0, 58);
		fs.ver = 8'h1F;
		fs.op = 8'd39;
		queue_frame(fs);
		// Opcode errors, one of them also with a bad request.
		fs = raps_frame(1'b0, REQ_SF, 48'h0, 56);
		fs.op = 8'd41;
		queue_frame(fs);
		fs = raps_frame(1'b0, REQ_SF, 48'h0, 56);
		fs.op = 8'hFF;
		fs.req = 8'hFF;
		queue_frame(fs);
		// Unknown request codes.
		fs = raps_frame(1'b1, REQ_NR, 48'h0, 62);
		fs.req = 8'h10;
		queue_frame(fs);
		fs = raps_frame(1'b0, REQ_NR, 48'h0, 55);
		fs.req = 8'hF0;
		queue_frame(fs);
		// Half of the VLAN type is not a tag.
		fs = raps_frame(1'b0, REQ_FS, 48'h0, 57);
		fs.etype = 16'h8101;
		queue_frame(fs);
		drain();

		// Highest node address: one frame from this node, one from a neighbor.
		write_node('1);
		gaps_on = 1'b0;
		stall_on = 1'b0;
		queue_frame(raps_frame(1'b0, REQ_NR, '1, 55));
		queue_frame(raps_frame(1'b1, REQ_SF, 48'hFFFF_FFFF_FFFE, 60));
		drain();

		// Random phases until the byte budget is used; each starts once the last has drained.
		phase = 0;
		while (bytes_queued < ITEM_TARGET) begin
			case (phase % 4)
				0: nd = 48'h0;
				1: nd = {16'($urandom), 32'($urandom)};
				2: nd = '1;
				default: nd = {16'($urandom), 32'($urandom)};
			endcase
			write_node(nd);
			gaps_on = (phase % 4 == 0) || (phase % 4 == 2);
			stall_on = (phase % 4 == 0) || (phase % 4 == 3);
			for (k = 0; k < 8 && bytes_queued < ITEM_TARGET; k++)
				random_frame();
			drain();
			phase++;
		end

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
